FILE: hw/rtl/vertex_weld_dedup_assert.svh
// assertion macros for the vertex welder
// used by the top level only, expects clk and arst_n in scope
`ifndef VERTEX_WELD_DEDUP_ASSERT_SVH
`define VERTEX_WELD_DEDUP_ASSERT_SVH

// same-cycle implication
`define VWD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define VWD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/vwd_pkg.sv
`timescale 1ns / 1ps
// shared constants, request codes and control structs of the vertex welder
// no dependencies
package vwd_pkg;

	localparam int MAX_VERTICES_DEF = 4096;
	localparam int TABLE_SLOTS_DEF  = 8192;

	localparam int SCALE_W   = 40;
	localparam int KEY_W     = 40;
	localparam int POS_W     = 32;
	localparam int IDX_W     = 32;
	localparam int WTOT_W    = 13;
	localparam int RTOT_W    = 16;

	localparam logic [SCALE_W-1:0] SCALE_DEFAULT = 40'd256000000;
	localparam logic [KEY_W-1:0]   KEY_MAX       = 40'h7F_FFFF_FFFF;
	localparam logic [63:0]        HASH_SEED     = 64'd1469598103934665603;
	localparam logic [63:0]        HASH_MIX      = 64'h9e37_79b9_7f4a_7c15;
	localparam logic [RTOT_W-1:0]  RTOT_MAX      = 16'hFFFF;

	typedef enum logic [1:0] {
		REQ_VERTEX   = 2'd0,
		REQ_CORNER   = 2'd1,
		REQ_NEW_MESH = 2'd2
	} req_code_t;

	typedef struct packed {
		logic       load_item;
		logic       clear_mesh;
		logic       clr_step;
		logic       q_mul;
		logic       q_add;
		logic       h_xor;
		logic       h_mul;
		logic [1:0] coord;
		logic       probe_init;
		logic       probe_rd;
		logic       insert;
		logic       weld;
		logic       advance;
		logic       set_ovf;
		logic       corner_rd;
		logic       corner_fin;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic slot_free;
		logic slot_match;
		logic probe_last;
		logic clr_last;
	} status_t;

	typedef struct packed {
		logic [IDX_W-1:0]  out_index;
		logic              was_welded;
		logic              face_end;
		logic              face_kept;
		logic              overflow;
		logic [WTOT_W-1:0] welded_total;
		logic [RTOT_W-1:0] removed_total;
	} res_t;

endpackage

FILE: hw/rtl/vwd_if.sv
`timescale 1ns / 1ps
// request and result channel interfaces of the vertex welder
// no dependencies
interface vwd_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         req_type;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic [31:0]        corner_vertex;
	logic               last_corner;

	modport source (output valid, req_type, pos_x, pos_y, pos_z, corner_vertex, last_corner,
		input ready);
	modport sink (input valid, req_type, pos_x, pos_y, pos_z, corner_vertex, last_corner,
		output ready);
endinterface

interface vwd_res_if;
	logic        valid;
	logic        ready;
	logic [31:0] out_index;
	logic        was_welded;
	logic        face_end;
	logic        face_kept;
	logic        overflow;
	logic [12:0] welded_total;
	logic [15:0] removed_total;

	modport source (output valid, out_index, was_welded, face_end, face_kept, overflow,
		welded_total, removed_total, input ready);
	modport sink (input valid, out_index, was_welded, face_end, face_kept, overflow,
		welded_total, removed_total, output ready);
endinterface

FILE: hw/rtl/vwd_dp.sv
`timescale 1ns / 1ps
// datapath: quantizer, key hash, slot memory, remap memory, counters, face tracking
// depends on vwd_pkg
module vwd_dp #(
	parameter int MAX_VERTICES = 4096,
	parameter int TABLE_SLOTS  = 8192
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [vwd_pkg::SCALE_W-1:0]     cfg_wdata,
	input  logic signed [vwd_pkg::POS_W-1:0] in_pos_x,
	input  logic signed [vwd_pkg::POS_W-1:0] in_pos_y,
	input  logic signed [vwd_pkg::POS_W-1:0] in_pos_z,
	input  logic [vwd_pkg::IDX_W-1:0]       in_corner,
	input  logic                            in_last,
	input  vwd_pkg::cmd_t                   cmd,
	output vwd_pkg::status_t                status,
	output vwd_pkg::res_t                   out_data
);
	import vwd_pkg::*;

	localparam int SLOT_W = $clog2(TABLE_SLOTS);
	localparam int VIDX_W = $clog2(MAX_VERTICES);
	localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
	localparam int WORD_W = 1 + 3 * KEY_W + VIDX_W;

	typedef struct packed {
		logic              valid;
		logic [KEY_W-1:0]  kx;
		logic [KEY_W-1:0]  ky;
		logic [KEY_W-1:0]  kz;
		logic [VIDX_W-1:0] idx;
	} slot_t;

	logic [SCALE_W-1:0] scale_q;
	logic [SCALE_W-1:0] scale_eff;

	logic signed [POS_W-1:0] px_q, py_q, pz_q;
	logic [IDX_W-1:0]        corner_q;
	logic                    last_q;

	logic [POS_W-1:0]  coord;
	logic [31:0]       mag;
	logic              neg_q;
	logic [47:0]       prod_hi_q;
	logic [55:0]       prod_lo_q;
	logic [56:0]       rnd;
	logic [48:0]       q_sum;
	logic [KEY_W-1:0]  key_mag;
	logic [KEY_W-1:0]  key_q [3];

	logic [63:0] h_q, t_q, key_ext, t_next;

	logic [SLOT_W-1:0] pos_q, probe_n_q, clr_q;
	logic [WORD_W-1:0] slot_mem [TABLE_SLOTS];
	logic [WORD_W-1:0] slot_rd_q;
	slot_t             rd_slot, wr_slot;
	logic              slot_we;
	logic [SLOT_W-1:0] slot_waddr;

	logic [VIDX_W-1:0] remap_mem [MAX_VERTICES];
	logic [VIDX_W-1:0] remap_rd_q;

	logic [CNT_W-1:0]  vs_q, uniq_q, weld_q;
	logic [RTOT_W-1:0] removed_q;
	logic [1:0]        fd_q, fd_next;
	logic [IDX_W-1:0]  fst_q, snd_q, cidx;

	logic [IDX_W-1:0] res_idx_q;
	logic             res_weld_q, res_fend_q, res_fkept_q, res_ovf_q;

	assign scale_eff = (scale_q == '0) ? SCALE_DEFAULT : scale_q;

	// quantize one coordinate per pass: products, then round and saturate
	always_comb begin
		case (cmd.coord)
			2'd0:    coord = px_q;
			2'd1:    coord = py_q;
			default: coord = pz_q;
		endcase
		mag     = coord[POS_W-1] ? (~coord + 32'd1) : coord;
		rnd     = 57'(prod_lo_q) + 57'h80_0000;
		q_sum   = 49'(prod_hi_q) + 49'(rnd[56:24]);
		key_mag = (q_sum > 49'(KEY_MAX)) ? KEY_MAX : q_sum[KEY_W-1:0];
	end

	assign key_ext = {{(64 - KEY_W){key_q[cmd.coord][KEY_W-1]}}, key_q[cmd.coord]};
	assign t_next  = h_q ^ (key_ext + HASH_MIX + (h_q << 6) + (h_q >> 2));

	assign rd_slot = slot_t'(slot_rd_q);

	always_comb begin
		wr_slot = '0;
		if (cmd.insert) begin
			wr_slot.valid = 1'b1;
			wr_slot.kx    = key_q[0];
			wr_slot.ky    = key_q[1];
			wr_slot.kz    = key_q[2];
			wr_slot.idx   = uniq_q[VIDX_W-1:0];
		end
		slot_we    = cmd.clr_step | cmd.insert;
		slot_waddr = cmd.clr_step ? clr_q : pos_q;
	end

	assign status.full       = (vs_q >= CNT_W'(MAX_VERTICES));
	assign status.slot_free  = !rd_slot.valid;
	assign status.slot_match = rd_slot.valid && (rd_slot.kx == key_q[0])
		&& (rd_slot.ky == key_q[1]) && (rd_slot.kz == key_q[2]);
	assign status.probe_last = (probe_n_q == '1);
	assign status.clr_last   = (clr_q == '1);

	// corner remap and distinct-index tracking
	always_comb begin
		cidx    = (corner_q < IDX_W'(vs_q)) ? IDX_W'(remap_rd_q) : corner_q;
		fd_next = fd_q;
		case (fd_q)
			2'd0:    fd_next = 2'd1;
			2'd1:    if (cidx != fst_q) fd_next = 2'd2;
			2'd2:    if (cidx != fst_q && cidx != snd_q) fd_next = 2'd3;
			default: fd_next = fd_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (slot_we) slot_mem[slot_waddr] <= WORD_W'(wr_slot);
		if (cmd.probe_rd) slot_rd_q <= slot_mem[pos_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.insert || cmd.weld)
			remap_mem[vs_q[VIDX_W-1:0]] <= cmd.insert ? uniq_q[VIDX_W-1:0] : rd_slot.idx;
		if (cmd.corner_rd) remap_rd_q <= remap_mem[corner_q[VIDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q   <= SCALE_DEFAULT;
			clr_q     <= '0;
			vs_q      <= '0;
			uniq_q    <= '0;
			weld_q    <= '0;
			removed_q <= '0;
			fd_q      <= '0;
			fst_q     <= '0;
			snd_q     <= '0;
		end else begin
			if (cfg_we) scale_q <= cfg_wdata;
			if (cmd.clr_step) clr_q <= clr_q + 1'b1;
			if (cmd.clear_mesh) begin
				clr_q     <= '0;
				vs_q      <= '0;
				uniq_q    <= '0;
				weld_q    <= '0;
				removed_q <= '0;
				fd_q      <= '0;
				fst_q     <= '0;
				snd_q     <= '0;
			end
			if (cmd.insert) begin
				uniq_q <= uniq_q + 1'b1;
				vs_q   <= vs_q + 1'b1;
			end
			if (cmd.weld) begin
				weld_q <= weld_q + 1'b1;
				vs_q   <= vs_q + 1'b1;
			end
			if (cmd.corner_fin) begin
				if (last_q) begin
					fd_q  <= '0;
					fst_q <= '0;
					snd_q <= '0;
					if (fd_next != 2'd3 && removed_q != RTOT_MAX)
						removed_q <= removed_q + 1'b1;
				end else begin
					fd_q <= fd_next;
					if (fd_q == 2'd0) fst_q <= cidx;
					if (fd_q == 2'd1 && fd_next == 2'd2) snd_q <= cidx;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			px_q        <= in_pos_x;
			py_q        <= in_pos_y;
			pz_q        <= in_pos_z;
			corner_q    <= in_corner;
			last_q      <= in_last;
			h_q         <= HASH_SEED;
			res_idx_q   <= '0;
			res_weld_q  <= 1'b0;
			res_fend_q  <= 1'b0;
			res_fkept_q <= 1'b0;
			res_ovf_q   <= 1'b0;
		end
		if (cmd.q_mul) begin
			neg_q     <= coord[POS_W-1];
			prod_hi_q <= 48'(mag) * 48'(scale_eff[39:24]);
			prod_lo_q <= 56'(mag) * 56'(scale_eff[23:0]);
		end
		if (cmd.q_add) key_q[cmd.coord] <= neg_q ? (~key_mag + 1'b1) : key_mag;
		if (cmd.h_xor) t_q <= t_next;
		// multiply by the fnv prime 2^40 + 0x1b3
		if (cmd.h_mul)
			h_q <= (t_q << 40) + (t_q << 8) + (t_q << 7) + (t_q << 5) + (t_q << 4)
				+ (t_q << 1) + t_q;
		if (cmd.probe_init) begin
			pos_q     <= h_q[SLOT_W-1:0];
			probe_n_q <= '0;
		end
		if (cmd.advance) begin
			pos_q     <= pos_q + 1'b1;
			probe_n_q <= probe_n_q + 1'b1;
		end
		if (cmd.insert) res_idx_q <= IDX_W'(uniq_q[VIDX_W-1:0]);
		if (cmd.weld) begin
			res_idx_q  <= IDX_W'(rd_slot.idx);
			res_weld_q <= 1'b1;
		end
		if (cmd.set_ovf) res_ovf_q <= 1'b1;
		if (cmd.corner_fin) begin
			res_idx_q   <= cidx;
			res_fend_q  <= last_q;
			res_fkept_q <= last_q && (fd_next == 2'd3);
		end
		if (cmd.out_load) begin
			out_data.out_index     <= res_idx_q;
			out_data.was_welded    <= res_weld_q;
			out_data.face_end      <= res_fend_q;
			out_data.face_kept     <= res_fkept_q;
			out_data.overflow      <= res_ovf_q;
			out_data.welded_total  <= WTOT_W'(weld_q);
			out_data.removed_total <= removed_q;
		end
	end

endmodule

FILE: hw/rtl/vwd_ctrl.sv
`timescale 1ns / 1ps
// controller: sequences quantize, hash, probe, remap and table clearing
// depends on vwd_pkg
module vwd_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [1:0]       in_type,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  vwd_pkg::status_t status,
	output vwd_pkg::cmd_t    cmd
);
	import vwd_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_QMUL,
		S_QADD,
		S_HXOR,
		S_HMUL,
		S_PRB_INIT,
		S_PRB_RD,
		S_PRB_CMP,
		S_CRN_RD,
		S_CRN_FIN,
		S_DONE
	} state_t;

	state_t     state_q;
	logic [1:0] coord_q;
	logic       resp_q;
	logic       accept, out_free, miss;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_ready && in_valid;
	assign out_free = !out_valid || out_ready;
	assign miss     = !status.slot_free && !status.slot_match;

	always_comb begin
		cmd            = '0;
		cmd.coord      = coord_q;
		cmd.load_item  = accept;
		cmd.clear_mesh = accept && (in_type == REQ_NEW_MESH);
		cmd.clr_step   = (state_q == S_CLEAR);
		cmd.q_mul      = (state_q == S_QMUL);
		cmd.q_add      = (state_q == S_QADD);
		cmd.h_xor      = (state_q == S_HXOR);
		cmd.h_mul      = (state_q == S_HMUL);
		cmd.probe_init = (state_q == S_PRB_INIT) && !status.full;
		cmd.probe_rd   = (state_q == S_PRB_RD);
		cmd.insert     = (state_q == S_PRB_CMP) && status.slot_free;
		cmd.weld       = (state_q == S_PRB_CMP) && status.slot_match;
		cmd.advance    = (state_q == S_PRB_CMP) && miss && !status.probe_last;
		cmd.set_ovf    = ((state_q == S_PRB_INIT) && status.full)
			|| ((state_q == S_PRB_CMP) && miss && status.probe_last);
		cmd.corner_rd  = (state_q == S_CRN_RD);
		cmd.corner_fin = (state_q == S_CRN_FIN);
		cmd.out_load   = (state_q == S_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			coord_q   <= 2'd0;
			resp_q    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					if (status.clr_last) begin
						state_q <= resp_q ? S_DONE : S_IDLE;
						resp_q  <= 1'b0;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						case (req_code_t'(in_type))
							REQ_VERTEX: begin
								coord_q <= 2'd0;
								state_q <= S_QMUL;
							end
							REQ_CORNER:   state_q <= S_CRN_RD;
							REQ_NEW_MESH: begin
								resp_q  <= 1'b1;
								state_q <= S_CLEAR;
							end
							default:      state_q <= S_DONE;
						endcase
					end
				end
				S_QMUL: state_q <= S_QADD;
				S_QADD: begin
					if (coord_q == 2'd2) begin
						coord_q <= 2'd0;
						state_q <= S_HXOR;
					end else begin
						coord_q <= coord_q + 2'd1;
						state_q <= S_QMUL;
					end
				end
				S_HXOR: state_q <= S_HMUL;
				S_HMUL: begin
					if (coord_q == 2'd2) begin
						state_q <= S_PRB_INIT;
					end else begin
						coord_q <= coord_q + 2'd1;
						state_q <= S_HXOR;
					end
				end
				S_PRB_INIT: state_q <= status.full ? S_DONE : S_PRB_RD;
				S_PRB_RD:   state_q <= S_PRB_CMP;
				S_PRB_CMP: begin
					if (!miss || status.probe_last) state_q <= S_DONE;
					else state_q <= S_PRB_RD;
				end
				S_CRN_RD:  state_q <= S_CRN_FIN;
				S_CRN_FIN: state_q <= S_DONE;
				S_DONE: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: hw/rtl/vertex_weld_dedup.sv
`timescale 1ns / 1ps
// top level of the vertex welder: controller, datapath and channel wiring
// depends on vwd_pkg, vwd_if, vwd_ctrl, vwd_dp and vertex_weld_dedup_assert.svh
//
// channel   dir   handshake      contents
// req       in    valid/ready    req_type, pos_x/y/z, corner_vertex, last_corner
// res       out   valid/ready    out_index, flags, welded_total, removed_total
// cfg       in    cfg_we         inverse_epsilon
//
// one request at a time; a vertex runs three quantize passes on a shared multiplier pair,
// then three shift-and-add hash rounds, then one slot memory read per probe
// a corner does one remap memory read; a new mesh sweeps the slot memory
// after reset the slot memory is swept with req.ready low
// a stalled result holds in the output register; the next request is taken meanwhile
// TABLE_SLOTS must be a power of two
`include "vertex_weld_dedup_assert.svh"
module vertex_weld_dedup #(
	parameter int MAX_VERTICES = vwd_pkg::MAX_VERTICES_DEF,
	parameter int TABLE_SLOTS  = vwd_pkg::TABLE_SLOTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [vwd_pkg::SCALE_W-1:0] cfg_wdata,
	vwd_req_if.sink                     req,
	vwd_res_if.source                   res
);
	import vwd_pkg::*;

	cmd_t    cmd;
	status_t status;
	res_t    out_data;

	vwd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_type   (req.req_type),
		.in_ready  (req.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.status    (status),
		.cmd       (cmd)
	);

	vwd_dp #(
		.MAX_VERTICES (MAX_VERTICES),
		.TABLE_SLOTS  (TABLE_SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_pos_x  (req.pos_x),
		.in_pos_y  (req.pos_y),
		.in_pos_z  (req.pos_z),
		.in_corner (req.corner_vertex),
		.in_last   (req.last_corner),
		.cmd       (cmd),
		.status    (status),
		.out_data  (out_data)
	);

	assign res.out_index     = out_data.out_index;
	assign res.was_welded    = out_data.was_welded;
	assign res.face_end      = out_data.face_end;
	assign res.face_kept     = out_data.face_kept;
	assign res.overflow      = out_data.overflow;
	assign res.welded_total  = out_data.welded_total;
	assign res.removed_total = out_data.removed_total;

	`VWD_ASSERT_NXT(a_busy_after_req, req.valid && req.ready, !req.ready, "request overlap")
	`VWD_ASSERT_IMP(a_ovf_clean, res.valid && res.overflow, res.out_index == 0 && !res.was_welded, "dropped vertex result not clean")
	`VWD_ASSERT_IMP(a_kept_end, res.valid && !res.face_end, !res.face_kept, "face kept without face end")
	`VWD_ASSERT_IMP(a_one_probe_cmd, 1'b1, $onehot0({cmd.insert, cmd.weld, cmd.advance, cmd.set_ovf}), "conflicting probe outcome")

endmodule
